[hw/rtl/plcm_pkg.sv]
// Shared types, constants and address helpers of the piecewise-linear curve map.
package plcm_pkg;

   // Item kinds carried in the opcode field.
   localparam logic OP_APPLY = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Write targets carried in the store_select field.
   localparam logic STORE_NINE = 1'b0;
   localparam logic STORE_FIVE = 1'b1;

   // Curve geometry.
   localparam int CURVE_COUNT = 8;
   localparam int FIVE_POINTS = 5;
   localparam int NINE_POINTS = 9;

   // Both point stores share one memory: nine-point curves first, then five-point curves.
   localparam int NINE_BASE = 0;
   localparam int FIVE_BASE = CURVE_COUNT * NINE_POINTS;
   localparam int MEM_DEPTH = FIVE_BASE + CURVE_COUNT * FIVE_POINTS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // Codes whose magnitude has this value in bits 6:4 select a curve.
   localparam logic [2:0] CURVE_CLASS = 3'b001;

   // Sample value that always reads the last point of a curve.
   localparam logic [7:0] SAMPLE_LAST = 8'hFF;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        sample;
      logic signed [7:0] curve_code;
      logic              store_select;
      logic [2:0]        curve_slot;
      logic [3:0]        point_index;
      logic [7:0]        point_value;
   } plcm_req_type;

   typedef struct packed {
      logic [7:0] mapped_value;
   } plcm_rsp_type;

   // First memory address of a nine-point curve.
   function automatic addr_type nine_base(input logic [2:0] slot);
      return addr_type'(NINE_BASE) + addr_type'({slot, 3'b000}) + addr_type'(slot);
   endfunction

   // First memory address of a five-point curve.
   function automatic addr_type five_base(input logic [2:0] slot);
      return addr_type'(FIVE_BASE) + addr_type'({slot, 2'b00}) + addr_type'(slot);
   endfunction

endpackage

[hw/rtl/plcm_channels_if.sv]
// Valid/ready channel interfaces for the request and response beats of the curve map.
interface plcm_req_if;
   import plcm_pkg::*;

   logic         valid;
   logic         ready;
   plcm_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface plcm_rsp_if;
   import plcm_pkg::*;

   logic         valid;
   logic         ready;
   plcm_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/piecewise_linear_curve_map_unit.sv]
// Top level of the piecewise-linear curve map: point memory, interpolation pipeline, result register.
//
// The request channel (req_chan) takes two kinds of beats. A write beat loads one curve point
// into the point memory and produces no response. An apply beat maps its sample through the
// curve chosen by its signed curve code (a negative code inverts the sample first) and
// produces exactly one response beat on rsp_chan carrying the mapped value.
// An accepted apply beat has its point reads registered in stage 1 and its result in the response
// register. Throughput: one beat per cycle, sustained, as long as the receiver takes responses;
// the two point reads that one apply needs are served by the two read ports of the point memory
// in the cycle of acceptance, so back-to-back applies and writes in any mix run at full rate.
// A write is visible to an apply accepted in the very next cycle, since the memory is written
// at the acceptance edge of the write and read at the acceptance edge of the later apply.
// Reset clears the pipeline valid flags only; the point memory keeps its contents, and a point
// must be written before any apply reads it. When the receiver stalls, the response register
// holds its beat, the interpolation stage fills behind it, and req_chan.ready then drops until
// the response is taken. No beat is lost or duplicated across a stall.
module piecewise_linear_curve_map_unit (
   input  logic        clock,
   input  logic        reset,
   plcm_req_if.sink    req_chan,
   plcm_rsp_if.source  rsp_chan
);
   import plcm_pkg::*;

   // Control carried from the decode stage to the interpolation stage.
   typedef struct packed {
      logic       mapped;   // a curve applies; otherwise the sample passes through
      logic       five;     // five-point curve, 64-sample segments
      logic       on_point; // sample sits on a point: result is the first point read
      logic [5:0] off;      // offset of the sample within its segment
      logic [7:0] x;        // sample after optional inversion
   } stage_ctl_type;

   // Point memory holding both stores.
   logic [7:0] point_mem [MEM_DEPTH];

   // Stage 1: memory read data and control.
   logic          s1_valid_ff;
   stage_ctl_type s1_ctl_ff;
   stage_ctl_type s1_ctl_in;
   logic [7:0]    rd0_ff;
   logic [7:0]    rd1_ff;

   // Response register.
   logic          out_valid_ff;
   logic [7:0]    out_value_ff;
   logic [7:0]    out_value_in;

   // Handshake.
   logic          advance;
   logic          req_fire;
   logic          apply_fire;
   logic          write_fire;

   // Decode of the incoming beat.
   logic [7:0]    code_bits;
   logic          code_neg;
   logic [6:0]    code_mag;
   logic [7:0]    neg_code;
   logic [7:0]    x_in;
   logic          sel_five;
   logic [2:0]    sel_slot;
   logic [3:0]    seg_idx;
   addr_type      rd_base;
   addr_type      rd_addr0;
   addr_type      rd_addr1;

   // Write decode.
   logic          wr_idx_ok;
   addr_type      wr_base;
   addr_type      wr_addr;

   // Interpolation.
   logic [7:0]    diff;
   logic [13:0]   prod;
   logic [7:0]    step;

   // The response register moves whenever it is empty or being taken; stage 1 follows it.
   assign advance      = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire     = req_chan.valid && req_chan.ready;
   assign apply_fire   = req_fire && (req_chan.payload.opcode == OP_APPLY);
   assign write_fire   = req_fire && (req_chan.payload.opcode == OP_WRITE);

   // A negative code inverts the sample and selects by magnitude; minus 128 has magnitude zero
   // and therefore passes the inverted sample through.
   always_comb begin
      code_bits = req_chan.payload.curve_code;
      code_neg  = code_bits[7];
      neg_code  = 8'(~code_bits + 8'd1);
      code_mag  = code_neg ? neg_code[6:0] : code_bits[6:0];
      x_in      = code_neg ? ~req_chan.payload.sample : req_chan.payload.sample;
      sel_five  = code_mag[3];
      sel_slot  = code_mag[2:0];

      // Segment index; the last sample value reads the last point of the curve.
      if (x_in == SAMPLE_LAST) begin
         seg_idx = sel_five ? 4'(FIVE_POINTS - 1) : 4'(NINE_POINTS - 1);
      end else begin
         seg_idx = sel_five ? {2'b00, x_in[7:6]} : {1'b0, x_in[7:5]};
      end

      rd_base  = sel_five ? five_base(sel_slot) : nine_base(sel_slot);
      rd_addr0 = rd_base + addr_type'(seg_idx);
      rd_addr1 = rd_addr0 + addr_type'(1);

      s1_ctl_in.mapped   = (code_mag[6:4] == CURVE_CLASS);
      s1_ctl_in.five     = sel_five;
      s1_ctl_in.off      = sel_five ? x_in[5:0] : {1'b0, x_in[4:0]};
      s1_ctl_in.on_point = (x_in == SAMPLE_LAST) || (s1_ctl_in.off == 6'd0);
      s1_ctl_in.x        = x_in;
   end

   // Writes beyond the last point of a curve are dropped.
   always_comb begin
      if (req_chan.payload.store_select == STORE_FIVE) begin
         wr_idx_ok = (req_chan.payload.point_index < 4'(FIVE_POINTS));
         wr_base   = five_base(req_chan.payload.curve_slot);
      end else begin
         wr_idx_ok = (req_chan.payload.point_index < 4'(NINE_POINTS));
         wr_base   = nine_base(req_chan.payload.curve_slot);
      end
      wr_addr = wr_base + addr_type'(req_chan.payload.point_index);
   end

   // Point memory: one write port, two registered read ports. Reads happen only when an
   // apply beat is accepted, so the read data stays put while stage 1 is stalled.
   always_ff @(posedge clock) begin
      if (write_fire && wr_idx_ok) begin
         point_mem[wr_addr] <= req_chan.payload.point_value;
      end
      if (apply_fire) begin
         rd0_ff <= point_mem[rd_addr0];
         rd1_ff <= point_mem[rd_addr1];
      end
   end

   // Stage 1 control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= apply_fire;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (apply_fire) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Interpolation: start + floor(off * ((next - start) mod 256) / segment length).
   always_comb begin
      diff = rd1_ff - rd0_ff;
      prod = 14'(s1_ctl_ff.off) * 14'(diff);
      step = s1_ctl_ff.five ? prod[13:6] : prod[12:5];
      if (!s1_ctl_ff.mapped) begin
         out_value_in = s1_ctl_ff.x;
      end else if (s1_ctl_ff.on_point) begin
         out_value_in = rd0_ff;
      end else begin
         out_value_in = rd0_ff + step;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.payload.mapped_value = out_value_ff;

`ifndef SYNTHESIS
   // A write beat never occupies the interpolation stage.
   assert property (@(posedge clock) disable iff (reset)
      write_fire |=> !s1_valid_ff)
      else $error("write beat entered the interpolation stage");

   // Every accepted apply beat is in stage 1 on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      apply_fire |=> s1_valid_ff)
      else $error("accepted apply beat was lost before stage 1");

   // A stage 1 item that moves on lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> out_valid_ff)
      else $error("stage 1 item did not reach the response register");
`endif

endmodule
